// ===== rtl/core/tos_pkg.sv =====
// ----------------------------------------------------------------------------
// tos_pkg
// Shared constants, types and helpers of the thrust overflow scaler.
// ----------------------------------------------------------------------------
`default_nettype none

package tos_pkg;

   // vector shape
   localparam int NUM_THR   = 8;
   localparam int THR_W     = 16;
   localparam int LIM_W     = 15;
   localparam int FRAC_BITS = 10;

   // limit after reset
   localparam logic [LIM_W-1:0] LIM_RESET = '1;

   // pipeline: three front stages, one stage per quotient bit, output stage
   localparam int NSTG = 4 + FRAC_BITS;
   localparam int DIV0 = 3;

   // restoring divider state of one word
   typedef struct packed {
      logic [LIM_W-1:0]     rem;
      logic [LIM_W-1:0]     dvs;
      logic [FRAC_BITS-1:0] quo;
   } div_type;

   // contents of one pipeline stage
   typedef struct packed {
      logic [NUM_THR-1:0][THR_W-1:0]   cmd;
      logic [NUM_THR/2-1:0][THR_W-1:0] mx;
      logic                            scaled;
      div_type                         div;
      logic [NUM_THR-1:0][THR_W-1:0]   res;
   } stage_type;

   // larger of two signed commands
   function automatic logic [THR_W-1:0] smax(input logic [THR_W-1:0] a,
                                             input logic [THR_W-1:0] b);
      return ($signed(a) > $signed(b)) ? a : b;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/tos_div_step.sv =====
// ----------------------------------------------------------------------------
// tos_div_step
// One restoring division step: doubles the remainder and takes out the
// divisor when it fits, shifting one quotient bit in.
// ----------------------------------------------------------------------------
`default_nettype none

module tos_div_step
   import tos_pkg::*;
(
   input  wire div_type div_i,
   output div_type      div_o
);

   logic [LIM_W:0] rem2;
   logic           fits;

   // trial subtract of the doubled remainder
   assign rem2 = {div_i.rem, 1'b0};
   assign fits = (rem2 >= {1'b0, div_i.dvs});

   always_comb begin
      div_o.dvs = div_i.dvs;
      div_o.quo = {div_i.quo[FRAC_BITS-2:0], fits};
      if (fits) begin
         div_o.rem = LIM_W'(rem2 - {1'b0, div_i.dvs});
      end else begin
         div_o.rem = rem2[LIM_W-1:0];
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/tos_lane.sv =====
// ----------------------------------------------------------------------------
// tos_lane
// One thruster lane: multiplies the command by the fixed-point scale and
// drops the fraction bits, truncating toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module tos_lane
   import tos_pkg::*;
(
   input  wire  [THR_W-1:0]     cmd,
   input  wire  [FRAC_BITS-1:0] scale,
   input  wire                  scaled,
   output logic [THR_W-1:0]     res
);

   logic                       neg;
   logic [THR_W-1:0]           mag;
   logic [THR_W+FRAC_BITS-1:0] prod;
   logic [THR_W-1:0]           q;

   // magnitude, the most negative command maps to its unsigned value
   assign neg  = cmd[THR_W-1];
   assign mag  = neg ? THR_W'(~cmd + 1'b1) : cmd;
   assign prod = mag * scale;
   assign q    = prod[THR_W+FRAC_BITS-1:FRAC_BITS];

   // restore the sign or pass through
   always_comb begin
      if (!scaled) begin
         res = cmd;
      end else if (neg) begin
         res = THR_W'(~q + 1'b1);
      end else begin
         res = q;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/thrust_overflow_scaler.sv =====
// ----------------------------------------------------------------------------
// thrust_overflow_scaler
// Proportional desaturation of an eight-thruster command vector.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one vector of eight signed 16-bit commands per word.
//   rsp_* returns the same vector, scaled down by limit/peak when the
//   signed peak exceeds the configured limit, and a flag in rsp_tuser.
//   csr_we/csr_wdata set the limit; write it only while the block is idle.
// Pipeline: 4 + FRAC_BITS stages. Three stages form the signed peak and
//   compare it, the restoring divider takes one stage per quotient bit and
//   the eight lane multipliers fill the output register.
// Throughput: one vector per cycle unless the pipeline stalls; every stage has its own valid bit.
// Stall: a stage holds while it is full and the stage after it cannot take
//   a word, so bubbles close up and req_tready falls only once all stages
//   are full with rsp_tready low.
// Reset: empties the pipeline and sets the limit to 32767.
// ----------------------------------------------------------------------------
`default_nettype none

module thrust_overflow_scaler
   import tos_pkg::*;
(
   input  wire                      clock,
   input  wire                      reset,
   // configuration
   input  wire                      csr_we,
   input  wire  [LIM_W-1:0]         csr_wdata,   // thrust_limit
   // command vector
   input  wire                      req_tvalid,
   output logic                     req_tready,
   input  wire  [NUM_THR*THR_W-1:0] req_tdata,   // thrust_0 .. thrust_7
   // scaled vector
   output logic                     rsp_tvalid,
   input  wire                      rsp_tready,
   output logic [NUM_THR*THR_W-1:0] rsp_tdata,   // out_0 .. out_7
   output logic                     rsp_tuser    // was_scaled
);

   logic [LIM_W-1:0]        limit_ff;
   logic [NSTG-1:0]         valid_ff;
   logic [NSTG:0]           ready;
   stage_type               stg_ff [NSTG];
   stage_type               stg_in [NSTG];
   div_type                 div_nx [FRAC_BITS];
   logic [THR_W-1:0]        lane_res [NUM_THR];

   // limit register
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIM_RESET;
      end else if (csr_we) begin
         limit_ff <= csr_wdata;
      end
   end

   // per-stage ready chain
   always_comb begin
      ready[NSTG] = rsp_tready;
      for (int i = NSTG - 1; i >= 0; i--) begin
         ready[i] = !valid_ff[i] || ready[i+1];
      end
   end

   assign req_tready = ready[0];

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (ready[0]) begin
            valid_ff[0] <= req_tvalid;
         end
         for (int i = 1; i < NSTG; i++) begin
            if (ready[i]) begin
               valid_ff[i] <= valid_ff[i-1];
            end
         end
      end
   end

   // divider steps, one per quotient bit
   for (genvar j = 0; j < FRAC_BITS; j++) begin : g_div
      tos_div_step u_step (
         .div_i (stg_ff[DIV0+j-1].div),
         .div_o (div_nx[j])
      );
   end

   // lanes apply the common scale
   for (genvar k = 0; k < NUM_THR; k++) begin : g_lane
      tos_lane u_lane (
         .cmd    (stg_ff[NSTG-2].cmd[k]),
         .scale  (stg_ff[NSTG-2].div.quo),
         .scaled (stg_ff[NSTG-2].scaled),
         .res    (lane_res[k])
      );
   end

   // next contents of every stage
   always_comb begin
      logic [THR_W-1:0] peak;
      stg_in = stg_ff;

      // pairwise maxima of the incoming vector
      stg_in[0].cmd = req_tdata;
      for (int i = 0; i < NUM_THR / 2; i++) begin
         stg_in[0].mx[i] = smax(req_tdata[2*i*THR_W +: THR_W],
                                req_tdata[(2*i+1)*THR_W +: THR_W]);
      end

      // second level of the max tree
      stg_in[1] = stg_ff[0];
      stg_in[1].mx[0] = smax(stg_ff[0].mx[0], stg_ff[0].mx[1]);
      stg_in[1].mx[1] = smax(stg_ff[0].mx[2], stg_ff[0].mx[3]);

      // peak against limit, divider seeded with the limit
      peak = smax(stg_ff[1].mx[0], stg_ff[1].mx[1]);
      stg_in[2] = stg_ff[1];
      stg_in[2].scaled  = ($signed(peak) > $signed({1'b0, limit_ff}));
      stg_in[2].div.rem = limit_ff;
      stg_in[2].div.dvs = peak[LIM_W-1:0];
      stg_in[2].div.quo = '0;

      // quotient bits
      for (int j = 0; j < FRAC_BITS; j++) begin
         stg_in[DIV0+j]     = stg_ff[DIV0+j-1];
         stg_in[DIV0+j].div = div_nx[j];
      end

      // lane results into the output register
      stg_in[NSTG-1] = stg_ff[NSTG-2];
      for (int k = 0; k < NUM_THR; k++) begin
         stg_in[NSTG-1].res[k] = lane_res[k];
      end
   end

   // stage data, no reset needed
   always_ff @(posedge clock) begin
      for (int i = 0; i < NSTG; i++) begin
         if (ready[i]) begin
            stg_ff[i] <= stg_in[i];
         end
      end
   end

   // result word
   assign rsp_tvalid = valid_ff[NSTG-1];
   assign rsp_tdata  = stg_ff[NSTG-1].res;
   assign rsp_tuser  = stg_ff[NSTG-1].scaled;

`ifndef SYNTHESIS
   // pipeline is empty right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // input stalls only when every stage holds a word
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (valid_ff == '1))
      else $error("input stalled with an empty stage");

   // divider remainder of a scaled word is below the divisor after the first step
   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      valid_ff[DIV0] && stg_ff[DIV0].scaled |->
         (stg_ff[DIV0].div.rem < stg_ff[DIV0].div.dvs))
      else $error("divider remainder not below divisor");

   // scaling never grows a command
   for (genvar k = 0; k < NUM_THR; k++) begin : g_chk
      a_no_grow: assert property (@(posedge clock) disable iff (reset)
         rsp_tvalid |->
            (($signed(stg_ff[NSTG-1].cmd[k]) >= 0) &&
             ($signed(stg_ff[NSTG-1].res[k]) >= 0) &&
             ($signed(stg_ff[NSTG-1].res[k]) <= $signed(stg_ff[NSTG-1].cmd[k]))) ||
            (($signed(stg_ff[NSTG-1].cmd[k]) < 0) &&
             ($signed(stg_ff[NSTG-1].res[k]) <= 0) &&
             ($signed(stg_ff[NSTG-1].res[k]) >= $signed(stg_ff[NSTG-1].cmd[k]))))
         else $error("lane result larger than its command");
   end
`endif

endmodule

`default_nettype wire
